// ----- hw/rtl/uft_pkg.sv -----
// Package: widths, command codes and the controller/datapath command and status types.
`timescale 1ns / 1ps
package uft_pkg;

  localparam int NODES  = 16384;
  localparam int NODE_W = $clog2(NODES);
  localparam int ID_W   = 14;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 15;

  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LINK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CMD_W-1:0]  cmd_code_t;

  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic sel_b;
    logic seen_rd;
    logic mark_set;
    logic find_start;
    logic par_rd;
    logic walk_adv;
    logic root_found;
    logic comp_wr;
    logic save_ra;
    logic merge;
    logic set_same;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t op;
    logic      seen_q;
    logic      par_is_root;
    logic      roots_differ;
    logic      clear_last;
    logic      out_free;
  } dp_stat_t;

  function automatic node_t node_index(id_t id);
    return node_t'(id % NODES);
  endfunction

endpackage

// ----- hw/rtl/uft_if.sv -----
// Interfaces: request channel and result channel, valid/ready with payload.
`timescale 1ns / 1ps
interface uft_req_if;
  import uft_pkg::*;
  logic      valid;
  logic      ready;
  cmd_code_t command;
  id_t       node_a;
  id_t       node_b;
  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

interface uft_res_if;
  import uft_pkg::*;
  logic valid;
  logic ready;
  logic same_set;
  cnt_t set_count;
  cnt_t member_count;
  modport source (output valid, same_set, set_count, member_count, input ready);
  modport sink   (input valid, same_set, set_count, member_count, output ready);
endinterface

// ----- hw/rtl/uft_ctrl.sv -----
// Controller: state machine that sequences clearing, marking, root walks and compression.
`timescale 1ns / 1ps
module uft_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  uft_pkg::dp_stat_t stat,
  output uft_pkg::dp_cmd_t  cmd
);
  import uft_pkg::*;

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_DISPATCH   = 4'd2;
  localparam logic [3:0] S_MARK_RD    = 4'd3;
  localparam logic [3:0] S_MARK_WR    = 4'd4;
  localparam logic [3:0] S_FIND_START = 4'd5;
  localparam logic [3:0] S_FIND_RD    = 4'd6;
  localparam logic [3:0] S_FIND_CHK   = 4'd7;
  localparam logic [3:0] S_COMP_RD    = 4'd8;
  localparam logic [3:0] S_COMP_CHK   = 4'd9;
  localparam logic [3:0] S_MERGE      = 4'd10;
  localparam logic [3:0] S_DONE       = 4'd11;

  logic [3:0] state, state_next;
  logic       second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.sel_b   = second;
    state_next  = state;
    second_next = second;
    req_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          second_next = 1'b0;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          CMD_MARK, CMD_LINK: state_next = S_MARK_RD;
          CMD_QUERY:          state_next = S_FIND_START;
          default:            state_next = S_DONE;
        endcase
      end
      S_MARK_RD: begin
        cmd.seen_rd = 1'b1;
        state_next  = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_set = !stat.seen_q;
        if (stat.op == CMD_LINK && !second) begin
          second_next = 1'b1;
          state_next  = S_MARK_RD;
        end else if (stat.op == CMD_LINK) begin
          second_next = 1'b0;
          state_next  = S_FIND_START;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIND_START: begin
        cmd.find_start = 1'b1;
        state_next     = S_FIND_RD;
      end
      S_FIND_RD: begin
        cmd.par_rd = 1'b1;
        state_next = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (stat.par_is_root) begin
          cmd.root_found = 1'b1;
          state_next     = S_COMP_RD;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = S_FIND_RD;
        end
      end
      S_COMP_RD: begin
        cmd.par_rd = 1'b1;
        state_next = S_COMP_CHK;
      end
      S_COMP_CHK: begin
        if (!stat.par_is_root) begin
          cmd.comp_wr = 1'b1;
          state_next  = S_COMP_RD;
        end else if (!second) begin
          cmd.save_ra = 1'b1;
          second_next = 1'b1;
          state_next  = S_FIND_START;
        end else begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge    = (stat.op == CMD_LINK) && stat.roots_differ;
        cmd.set_same = (stat.op == CMD_QUERY);
        second_next  = 1'b0;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/uft_dpath.sv -----
// Datapath: parent table and seen map memories, walk registers, counters, result register.
`timescale 1ns / 1ps
module uft_dpath (
  input  logic               clk,
  input  logic               rst,
  input  uft_pkg::cmd_code_t command,
  input  uft_pkg::id_t       node_a,
  input  uft_pkg::id_t       node_b,
  input  uft_pkg::dp_cmd_t   cmd,
  output uft_pkg::dp_stat_t  stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               same_set,
  output uft_pkg::cnt_t      set_count,
  output uft_pkg::cnt_t      member_count
);
  import uft_pkg::*;

  node_t     parent_mem [NODES];
  logic      seen_mem   [NODES];

  cmd_code_t op;
  node_t     a, b, cur, start, root, ra, par_q, clr_idx;
  logic      seen_q, same;
  cnt_t      sets_cnt, seen_cnt;

  node_t     sel_node, par_waddr, par_wdata, seen_waddr;
  logic      par_we, seen_we;

  assign sel_node   = cmd.sel_b ? b : a;
  assign par_we     = cmd.clear_wr | cmd.comp_wr | cmd.merge;
  assign par_waddr  = cmd.clear_wr ? clr_idx : (cmd.merge ? ra : cur);
  assign par_wdata  = cmd.clear_wr ? clr_idx : root;
  assign seen_we    = cmd.clear_wr | cmd.mark_set;
  assign seen_waddr = cmd.clear_wr ? clr_idx : sel_node;

  always_ff @(posedge clk) begin
    if (par_we) parent_mem[par_waddr] <= par_wdata;
    if (cmd.par_rd) par_q <= parent_mem[cur];
    if (seen_we) seen_mem[seen_waddr] <= cmd.mark_set;
    if (cmd.seen_rd) seen_q <= seen_mem[sel_node];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= command;
      a  <= node_index(node_a);
      b  <= node_index(node_b);
    end
    if (cmd.find_start) begin
      cur   <= sel_node;
      start <= sel_node;
    end else if (cmd.walk_adv || cmd.comp_wr) begin
      cur <= par_q;
    end else if (cmd.root_found) begin
      cur  <= start;
      root <= cur;
    end
    if (cmd.save_ra) ra <= root;
    if (cmd.capture) begin
      same <= 1'b0;
    end else if (cmd.set_same) begin
      same <= (ra == root);
    end
    if (cmd.load_out) begin
      same_set     <= same;
      set_count    <= sets_cnt;
      member_count <= seen_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      sets_cnt  <= '0;
      seen_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_idx <= clr_idx + node_t'(1);
      if (cmd.mark_set) begin
        sets_cnt <= sets_cnt + cnt_t'(1);
        seen_cnt <= seen_cnt + cnt_t'(1);
      end else if (cmd.merge) begin
        sets_cnt <= sets_cnt - cnt_t'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.op           = op;
  assign stat.seen_q       = seen_q;
  assign stat.par_is_root  = (par_q == cur);
  assign stat.roots_differ = (ra != root);
  assign stat.clear_last   = (clr_idx == node_t'(NODES - 1));
  assign stat.out_free     = !out_valid || out_ready;

endmodule

// ----- hw/rtl/union_find_set_tracker.sv -----
// Top level: union-find set tracker, controller and datapath joined by command and status.
//
// Channels: req (sink) carries command, node_a, node_b; rsp (source) carries
// same_set, set_count and member_count. Both transfer on valid and ready high.
// Every request yields exactly one result, in request order.
// One request is worked at a time; req.ready is high only while idle.
// The time from acceptance to result valid grows, for query and link, with
// the chain depths of node_a and node_b below their roots.
// The parent table has one read port with registered data, so each step of a
// root walk or of path compression takes a read state and a check state.
// Reset: a clearing pass writes all 16384 entries, setting the parent table to
// identity and clearing the seen map; req.ready stays low until it ends.
// A stalled result is held in the output register; the next request is taken
// meanwhile, and its result waits until the register is free.
`timescale 1ns / 1ps
module union_find_set_tracker (
  input logic   clk,
  input logic   rst,
  uft_req_if.sink   req,
  uft_res_if.source rsp
);
  import uft_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  uft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uft_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .command      (req.command),
    .node_a       (req.node_a),
    .node_b       (req.node_b),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .same_set     (rsp.same_set),
    .set_count    (rsp.set_count),
    .member_count (rsp.member_count)
  );

endmodule

// ----- hw/rtl/uft_checker.sv -----
// Checker: port-level assertions on the set tracker, bound to the top level.
`timescale 1ns / 1ps
module uft_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          same_set,
  input uft_pkg::cnt_t set_count,
  input uft_pkg::cnt_t member_count
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_sets_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> set_count <= member_count)
    else $error("more sets than seen nodes");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(same_set)
      && $stable(set_count) && $stable(member_count))
    else $error("stalled result changed");

endmodule

bind union_find_set_tracker uft_checker u_uft_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .same_set     (rsp.same_set),
  .set_count    (rsp.set_count),
  .member_count (rsp.member_count)
);

// ----- bench/tb_union_find_set_tracker.sv -----
// Testbench for the union-find set tracker: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module tb_union_find_set_tracker;
  import uft_pkg::*;

  localparam cmd_code_t CMD_SPARE      = 2'd3;
  localparam int        RANDOM_ITEMS   = 650;
  localparam int        LONG_HOLD      = 500;
  localparam int        WATCHDOG_LIMIT = 100000;
  localparam int        TAIL_CYCLES    = 60;

  typedef struct packed {
    logic same_set;
    cnt_t set_count;
    cnt_t member_count;
  } set_report_t;

  class set_tracker_scoreboard;
    node_t       parent_of [NODES];
    bit          is_member [NODES];
    cnt_t        sets_now;
    cnt_t        members_now;
    set_report_t expected_reports [$];
    int          failures;
    int          reports_checked;

    function new();
      for (int i = 0; i < NODES; i++) begin
        parent_of[i] = node_t'(i);
        is_member[i] = 1'b0;
      end
      sets_now        = '0;
      members_now     = '0;
      failures        = 0;
      reports_checked = 0;
    endfunction

    function node_t find_root(node_t n);
      node_t root;
      node_t nxt;
      int    steps;
      root  = n;
      steps = 0;
      while (parent_of[root] != root && steps < NODES) begin
        root = parent_of[root];
        steps++;
      end
      steps = 0;
      while (parent_of[n] != n && steps < NODES) begin
        nxt          = parent_of[n];
        parent_of[n] = root;
        n            = nxt;
        steps++;
      end
      return root;
    endfunction

    function void add_member(node_t n);
      if (!is_member[n]) begin
        is_member[n] = 1'b1;
        members_now  = members_now + 1'b1;
        sets_now     = sets_now + 1'b1;
      end
    endfunction

    function void note_request(cmd_code_t cmd, id_t a_id, id_t b_id);
      node_t       a;
      node_t       b;
      node_t       ra;
      node_t       rb;
      set_report_t rep;
      a            = node_t'(a_id % NODES);
      b            = node_t'(b_id % NODES);
      rep.same_set = 1'b0;
      case (cmd)
        CMD_MARK: begin
          add_member(a);
        end
        CMD_LINK: begin
          add_member(a);
          add_member(b);
          ra = find_root(a);
          rb = find_root(b);
          if (ra != rb) begin
            parent_of[ra] = rb;
            sets_now      = sets_now - 1'b1;
          end
        end
        CMD_QUERY: begin
          ra           = find_root(a);
          rb           = find_root(b);
          rep.same_set = (ra == rb);
        end
        default: begin
        end
      endcase
      rep.set_count    = sets_now;
      rep.member_count = members_now;
      expected_reports.push_back(rep);
    endfunction

    function void check_result(logic same, cnt_t sets, cnt_t members);
      set_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result same_set=%0b set_count=%0d member_count=%0d",
                 $time, same, sets, members);
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      if (same !== want.same_set) begin
        $display("%0t: same_set expected %0b actual %0b", $time, want.same_set, same);
        failures++;
      end
      if (sets !== want.set_count) begin
        $display("%0t: set_count expected %0d actual %0d", $time, want.set_count, sets);
        failures++;
      end
      if (members !== want.member_count) begin
        $display("%0t: member_count expected %0d actual %0d", $time, want.member_count,
                 members);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   quiet_cycles = 0;

  set_tracker_scoreboard tracker = new();

  uft_req_if req ();
  uft_res_if rsp ();

  union_find_set_tracker DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r < 12) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic id_t pick_node(id_t base, int span);
    if ($urandom_range(0, 9) == 0) begin
      return id_t'($urandom);
    end
    return id_t'(base + $urandom_range(0, span));
  endfunction

  task automatic offer_request(cmd_code_t cmd, id_t a_id, id_t b_id, int gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.node_a  <= a_id;
    req.node_b  <= b_id;
    do @(posedge clk); while (req.ready !== 1'b1);
    tracker.note_request(cmd, a_id, b_id);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (tracker.expected_reports.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      tracker.check_result(rsp.same_set, rsp.set_count, rsp.member_count);
    end
  end

  always @(posedge clk) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : result_taker
    int stall_left;
    int steady_left;
    bit long_hold_done;
    stall_left     = 0;
    steady_left    = 0;
    long_hold_done = 1'b0;
    rsp.ready      = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!long_hold_done && tracker.reports_checked >= 150) begin
        // hold off long enough for the block to back up into the request side
        long_hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (steady_left > 0) begin
        rsp.ready <= 1'b1;
        steady_left--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        case ($urandom_range(0, 9))
          0: steady_left = $urandom_range(20, 80);
          1, 2: stall_left = $urandom_range(1, 3);
          3: stall_left = $urandom_range(10, 40);
          default: begin
          end
        endcase
        rsp.ready <= (stall_left == 0);
      end
    end
  end

  initial begin : request_stream
    int        sent;
    int        next_shift;
    int        span;
    int        roll;
    bit        steady;
    bit        drained_once;
    id_t       base;
    id_t       chain_start;
    cmd_code_t cmd;
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.command  = CMD_MARK;
    req.node_a   = '0;
    req.node_b   = '0;
    sent         = 0;
    next_shift   = 0;
    span         = 7;
    steady       = 1'b0;
    drained_once = 1'b0;
    base         = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_request(CMD_MARK, 14'd0, 14'd0, pick_gap(0));
    offer_request(CMD_MARK, 14'h3FFF, 14'd0, pick_gap(0));
    offer_request(CMD_MARK, 14'd0, 14'h3FFF, pick_gap(0));
    offer_request(CMD_QUERY, 14'd0, 14'h3FFF, pick_gap(0));
    offer_request(CMD_LINK, 14'd0, 14'h3FFF, pick_gap(0));
    offer_request(CMD_QUERY, 14'd0, 14'h3FFF, pick_gap(0));
    offer_request(CMD_LINK, 14'h3FFF, 14'd0, pick_gap(0));
    offer_request(CMD_LINK, 14'h2AAA, 14'h1555, pick_gap(0));
    offer_request(CMD_LINK, 14'd5, 14'd5, pick_gap(0));
    offer_request(CMD_QUERY, 14'd7, 14'd9, pick_gap(0));
    offer_request(CMD_QUERY, 14'd7, 14'd7, pick_gap(0));
    offer_request(CMD_SPARE, 14'h3FFF, 14'h3FFF, pick_gap(0));
    offer_request(CMD_SPARE, 14'h1555, 14'h2AAA, pick_gap(0));
    offer_request(CMD_LINK, 14'd100, 14'd101, pick_gap(0));
    offer_request(CMD_LINK, 14'd101, 14'd102, pick_gap(0));
    offer_request(CMD_LINK, 14'd102, 14'd103, pick_gap(0));
    offer_request(CMD_LINK, 14'd103, 14'd104, pick_gap(0));
    offer_request(CMD_QUERY, 14'd100, 14'd104, pick_gap(0));
    offer_request(CMD_QUERY, 14'd100, 14'd104, pick_gap(0));
    offer_request(CMD_LINK, 14'd100, 14'd0, pick_gap(0));
    offer_request(CMD_QUERY, 14'h3FFF, 14'd104, pick_gap(0));
    offer_request(CMD_QUERY, 14'h1555, 14'd0, pick_gap(0));

    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_shift) begin
        next_shift = next_shift + 50;
        base       = id_t'($urandom);
        span       = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(7, 40);
        steady     = ($urandom_range(0, 2) == 0);
      end
      if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
        drained_once = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // build a deep chain, then walk it
        chain_start = pick_node(base, span);
        for (int j = 0; j < 6; j++) begin
          offer_request(CMD_LINK, id_t'(chain_start + j), id_t'(chain_start + j + 1),
                        pick_gap(steady));
        end
        offer_request(CMD_QUERY, chain_start, id_t'(chain_start + 6), pick_gap(steady));
        sent = sent + 7;
      end else begin
        if (roll < 25) begin
          cmd = CMD_MARK;
        end else if (roll < 60) begin
          cmd = CMD_LINK;
        end else if (roll < 95) begin
          cmd = CMD_QUERY;
        end else begin
          cmd = CMD_SPARE;
        end
        offer_request(cmd, pick_node(base, span), pick_node(base, span), pick_gap(steady));
        sent++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.failures == 0 && tracker.expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
